// ===== src/mtc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Markup tag counter package
// Shared types, constants and state codes for the tag counter.
// ----------------------------------------------------------------------------
package mtc_pkg;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic CMD_STREAM = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   localparam logic KIND_TAG  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef enum logic [1:0] {
      PARSE_IDLE  = 2'd0,
      PARSE_AFTER = 2'd1,
      PARSE_CLOSE = 2'd2,
      PARSE_OPEN  = 2'd3
   } parse_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_READ    = 3'd1,
      ST_COMPARE = 3'd2,
      ST_CHAR    = 3'd3,
      ST_UPDATE  = 3'd4,
      ST_REPLY   = 3'd5
   } ctrl_state_type;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
      logic [3:0] slot;
      logic [4:0] char_pos;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  entry_slot;
      logic [31:0] occurrences;
      logic        is_new;
      logic        dropped_full;
      logic [7:0]  name_char;
      logic [4:0]  name_length;
      logic [4:0]  entries_used;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic parse_byte;
      logic read_start;
      logic cmp_start;
      logic cmp_entry;
      logic cmp_char;
      logic cmp_next;
      logic cmp_hit;
      logic update;
      logic reply;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic name_done;
      logic entry_done;
      logic entries_done;
      logic char_done;
      logic char_eq;
   } sts_type;

endpackage
`default_nettype wire

// ===== src/mtc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Markup tag counter controller
// Sequences parsing, the table search and the result strobe.
// ----------------------------------------------------------------------------
module mtc_ctrl
   import mtc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            if (sts.is_read) begin
               cmd.read_start = 1'b1;
               state_in       = ST_REPLY;
            end else if (sts.name_done) begin
               cmd.cmp_start = 1'b1;
               state_in      = ST_COMPARE;
            end else begin
               cmd.parse_byte = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_COMPARE: begin
            if (sts.entries_done) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.cmp_entry = 1'b1;
               state_in      = ST_CHAR;
            end
         end
         ST_CHAR: begin
            if (sts.entry_done) begin
               cmd.cmp_hit = 1'b1;
               state_in    = ST_UPDATE;
            end else if (sts.char_done || !sts.char_eq) begin
               cmd.cmp_next = 1'b1;
               state_in     = ST_COMPARE;
            end else begin
               cmd.cmp_char = 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_REPLY;
         end
         ST_REPLY: begin
            cmd.reply = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_reply_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.reply |=> state_ff == ST_IDLE)
      else $error("reply not followed by idle");
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> busy)
      else $error("request accepted without going busy");
   a_update_then_reply: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> cmd.reply)
      else $error("update not followed by reply");
`endif

endmodule
`default_nettype wire

// ===== src/mtc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Markup tag counter datapath
// Name buffer, entry table memories, compare counters and the result register.
// ----------------------------------------------------------------------------
module mtc_datapath
   import mtc_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int NAME_BYTES = 19
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output rsp_type      rsp,
   output logic         rsp_valid
);

   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int NW = $clog2(NAME_BYTES + 1);
   localparam int BW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
   localparam int MW = ENTRIES * NAME_BYTES;
   localparam int AW = $clog2(MW);

   req_type        req_ff;
   parse_mode_type mode_ff;
   logic [7:0]     nbuf_ff [NAME_BYTES];
   logic [NW-1:0]  nlen_ff;
   logic [CW-1:0]  used_ff;

   logic [7:0]     key_mem [MW];
   logic [NW-1:0]  len_mem [ENTRIES];
   logic [31:0]    cnt_mem [ENTRIES];

   logic [CW-1:0]  ent_ff;
   logic [NW-1:0]  pos_ff;
   logic [7:0]     key_q_ff;
   logic [NW-1:0]  len_q_ff;
   logic [31:0]    cnt_q_ff;
   logic           found_ff;
   logic           valid_ff;
   logic           rv_ff;
   rsp_type        rsp_ff;

   logic [7:0]     b;
   logic           cur_done;
   logic [EW-1:0]  ent_idx;
   logic [EW-1:0]  rd_ent;
   logic [AW-1:0]  rd_addr;
   logic [AW-1:0]  wr_base;
   logic           room;
   logic [31:0]    cnt_inc;
   logic           add_byte;
   logic [BW-1:0]  add_idx;

   assign b       = req_ff.data_byte;
   assign ent_idx = ent_ff[EW-1:0];
   assign room    = (used_ff < CW'(ENTRIES));

   always_comb begin
      cur_done = 1'b0;
      if (mode_ff == PARSE_CLOSE) begin
         cur_done = (b == CHAR_GT);
      end else if (mode_ff == PARSE_OPEN) begin
         cur_done = (b == CHAR_GT) || (b == CHAR_SPACE);
      end
   end

   assign sts.is_read      = (req_ff.command == CMD_READ);
   assign sts.name_done    = cur_done;
   assign sts.entries_done = (ent_ff >= used_ff);
   assign sts.entry_done   = (pos_ff == len_q_ff) && (pos_ff == nlen_ff);
   assign sts.char_done    = (len_q_ff != nlen_ff);
   assign sts.char_eq      = (key_q_ff == nbuf_ff[pos_ff[BW-1:0]]) ||
                             (pos_ff == nlen_ff);

   always_comb begin
      rd_ent  = ent_idx;
      rd_addr = AW'(ent_idx) * AW'(NAME_BYTES) + AW'(pos_ff);
      if (sts.is_read) begin
         rd_ent  = req_ff.slot[EW-1:0];
         rd_addr = AW'(req_ff.slot[EW-1:0]) * AW'(NAME_BYTES) +
                   AW'(req_ff.char_pos[BW-1:0]);
      end else if (cmd.cmp_entry) begin
         rd_addr = AW'(ent_idx) * AW'(NAME_BYTES);
      end else if (cmd.cmp_char) begin
         rd_addr = AW'(ent_idx) * AW'(NAME_BYTES) + AW'(pos_ff) + AW'(1);
      end
   end

   // Name bytes are also written into the next free slot as they arrive, so
   // an insert only has to set the length and the count.
   assign add_byte = cmd.parse_byte && nlen_ff < NW'(NAME_BYTES) &&
                     ((mode_ff == PARSE_AFTER && b != CHAR_SLASH) ||
                      mode_ff == PARSE_CLOSE || mode_ff == PARSE_OPEN);
   assign add_idx  = (mode_ff == PARSE_AFTER) ? BW'(0) : nlen_ff[BW-1:0];

   assign wr_base = AW'(used_ff[EW-1:0]) * AW'(NAME_BYTES);
   assign cnt_inc = (cnt_q_ff == 32'hFFFF_FFFF) ? cnt_q_ff : cnt_q_ff + 32'd1;

   always_ff @(posedge clock) begin
      key_q_ff <= key_mem[rd_addr];
      len_q_ff <= len_mem[rd_ent];
      cnt_q_ff <= cnt_mem[rd_ent];
      if (add_byte && room) begin
         key_mem[wr_base + AW'(add_idx)] <= b;
      end
      if (cmd.update && found_ff) begin
         cnt_mem[ent_idx] <= cnt_inc;
      end else if (cmd.update && room) begin
         cnt_mem[used_ff[EW-1:0]] <= 32'd1;
         len_mem[used_ff[EW-1:0]] <= nlen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req;
      end
      if (add_byte) begin
         nbuf_ff[add_idx] <= b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= PARSE_IDLE;
         nlen_ff  <= '0;
         used_ff  <= '0;
         ent_ff   <= '0;
         pos_ff   <= '0;
         found_ff <= 1'b0;
         valid_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         rv_ff <= cmd.reply;
         if (cmd.parse_byte) begin
            unique case (mode_ff)
               PARSE_IDLE: begin
                  if (b == CHAR_LT) begin
                     mode_ff <= PARSE_AFTER;
                     nlen_ff <= '0;
                  end
               end
               PARSE_AFTER: begin
                  if (b == CHAR_SLASH) begin
                     mode_ff <= PARSE_CLOSE;
                     nlen_ff <= '0;
                  end else begin
                     mode_ff <= PARSE_OPEN;
                     nlen_ff <= NW'(1);
                  end
               end
               default: begin
                  if (nlen_ff < NW'(NAME_BYTES)) begin
                     nlen_ff <= nlen_ff + NW'(1);
                  end
               end
            endcase
         end
         if (cmd.read_start) begin
            valid_ff <= ({1'b0, req_ff.slot} < 5'(used_ff)) &&
                        (32'(req_ff.slot) < ENTRIES);
         end
         if (cmd.cmp_start) begin
            ent_ff   <= '0;
            pos_ff   <= '0;
            found_ff <= 1'b0;
         end
         if (cmd.cmp_entry) begin
            pos_ff <= '0;
         end
         if (cmd.cmp_char) begin
            pos_ff <= pos_ff + NW'(1);
         end
         if (cmd.cmp_next) begin
            ent_ff <= ent_ff + CW'(1);
         end
         if (cmd.cmp_hit) begin
            found_ff <= 1'b1;
         end
         if (cmd.update) begin
            mode_ff <= PARSE_IDLE;
            if (!found_ff && room) begin
               used_ff <= used_ff + CW'(1);
            end
         end
         if (cmd.reply && !sts.is_read) begin
            nlen_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_ff.kind         <= KIND_TAG;
         rsp_ff.name_char    <= '0;
         rsp_ff.name_length  <= 5'(nlen_ff);
         if (found_ff) begin
            rsp_ff.entry_slot   <= 4'(ent_idx);
            rsp_ff.occurrences  <= cnt_inc;
            rsp_ff.is_new       <= 1'b0;
            rsp_ff.dropped_full <= 1'b0;
            rsp_ff.entries_used <= 5'(used_ff);
         end else if (room) begin
            rsp_ff.entry_slot   <= 4'(used_ff[EW-1:0]);
            rsp_ff.occurrences  <= 32'd1;
            rsp_ff.is_new       <= 1'b1;
            rsp_ff.dropped_full <= 1'b0;
            rsp_ff.entries_used <= 5'(used_ff + CW'(1));
         end else begin
            rsp_ff.entry_slot   <= '0;
            rsp_ff.occurrences  <= '0;
            rsp_ff.is_new       <= 1'b0;
            rsp_ff.dropped_full <= 1'b1;
            rsp_ff.entries_used <= 5'(used_ff);
         end
      end
   end

   always_comb begin
      rsp = rsp_ff;
      if (req_ff.command == CMD_READ) begin
         rsp.kind         = KIND_READ;
         rsp.entry_slot   = req_ff.slot;
         rsp.is_new       = 1'b0;
         rsp.dropped_full = 1'b0;
         rsp.entries_used = 5'(used_ff);
         rsp.occurrences  = valid_ff ? cnt_q_ff : '0;
         rsp.name_length  = valid_ff ? 5'(len_q_ff) : '0;
         rsp.name_char    = (valid_ff && ({1'b0, req_ff.char_pos} < 6'(len_q_ff)))
                            ? key_q_ff : '0;
      end
   end

   assign rsp_valid = rv_ff;

`ifndef NO_ASSERTIONS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(ENTRIES))
      else $error("entry count beyond table size");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      nlen_ff <= NW'(NAME_BYTES))
      else $error("name length beyond buffer");
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.update |=> $stable(used_ff))
      else $error("entry count changed outside update");
`endif

endmodule
`default_nettype wire

// ===== src/markup_tag_counter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Markup tag counter unit
// Extracts tag names from a markup byte stream and counts them in a table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A stream byte
// request advances the tag parser; when it ends a name, the name is searched
// in the table entry by entry, one byte per cycle, then counted or inserted,
// and a tag report is strobed on rsp_valid for one cycle. A read request
// returns one name byte, the length and the count of a table entry.
// The search takes the stored entries in turn and compares one name byte
// after another while they match; a hit ends the search. Busy stays high
// until the request is done, so a new request waits for the last one.
// The result is registered and shown for exactly one cycle; the receiver
// cannot stall it. Reset clears the parser, the name length and the entry
// count; table contents are never read before they are written.
// ----------------------------------------------------------------------------
module markup_tag_counter_unit
   import mtc_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int NAME_BYTES = 19
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   cmd_type cmd;
   sts_type sts;

   mtc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   mtc_datapath #(
      .ENTRIES    (ENTRIES),
      .NAME_BYTES (NAME_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp       (rsp_data),
      .rsp_valid (rsp_valid)
   );

endmodule
`default_nettype wire

// ===== tb/markup_tag_counter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markup tag counter unit testbench
// Feeds tag markup and table reads through the command port and checks each
// strobed report against a behavioral model of the parser and the tag table.
// ----------------------------------------------------------------------------
module markup_tag_counter_unit_test;
   import mtc_pkg::*;

   localparam int ENTRIES    = 16;
   localparam int NAME_BYTES = 19;
   localparam int LIMIT      = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   markup_tag_counter_unit #(.ENTRIES(ENTRIES), .NAME_BYTES(NAME_BYTES)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   parse_mode_type mode;
   logic [7:0]     cur_name [NAME_BYTES];
   int             cur_len;
   logic [7:0]     tag_names [ENTRIES][NAME_BYTES];
   int             tag_lens [ENTRIES];
   logic [31:0]    tag_counts [ENTRIES];
   int             tag_used;

   rsp_type pending [$];
   int      errors = 0;
   int      cycles = 0;
   int      reports = 0;
   int      reads = 0;
   int      requests = 0;

   function automatic void add_char(logic [7:0] b);
      if (cur_len < NAME_BYTES) begin
         cur_name[cur_len] = b;
         cur_len++;
      end
   endfunction

   function automatic rsp_type count_tag();
      rsp_type r;
      int      hit;
      bit      eq;
      r = '0;
      hit = -1;
      for (int i = 0; i < tag_used && hit < 0; i++) begin
         if (tag_lens[i] == cur_len) begin
            eq = 1'b1;
            for (int j = 0; j < cur_len; j++) if (tag_names[i][j] != cur_name[j]) eq = 1'b0;
            if (eq) hit = i;
         end
      end
      r.kind = KIND_TAG;
      r.name_length = cur_len[4:0];
      if (hit >= 0) begin
         if (tag_counts[hit] != 32'hFFFF_FFFF) tag_counts[hit]++;
         r.entry_slot = hit[3:0];
         r.occurrences = tag_counts[hit];
      end else if (tag_used < ENTRIES) begin
         for (int j = 0; j < cur_len; j++) tag_names[tag_used][j] = cur_name[j];
         tag_lens[tag_used] = cur_len;
         tag_counts[tag_used] = 32'd1;
         r.entry_slot = tag_used[3:0];
         r.occurrences = 32'd1;
         r.is_new = 1'b1;
         tag_used++;
      end else begin
         r.dropped_full = 1'b1;
      end
      r.entries_used = tag_used[4:0];
      mode = PARSE_IDLE;
      cur_len = 0;
      return r;
   endfunction

   // Returns 1 and fills the expected report when the request causes one.
   function automatic bit predict_request(req_type q, output rsp_type r);
      r = '0;
      if (q.command == CMD_READ) begin
         r.kind = KIND_READ;
         r.entry_slot = q.slot;
         r.entries_used = tag_used[4:0];
         if (q.slot < tag_used) begin
            r.occurrences = tag_counts[q.slot];
            r.name_length = tag_lens[q.slot][4:0];
            if (q.char_pos < tag_lens[q.slot]) r.name_char = tag_names[q.slot][q.char_pos];
         end
         return 1;
      end
      case (mode)
         PARSE_IDLE: begin
            if (q.data_byte == CHAR_LT) begin
               mode = PARSE_AFTER;
               cur_len = 0;
            end
         end
         PARSE_AFTER: begin
            cur_len = 0;
            if (q.data_byte == CHAR_SLASH) mode = PARSE_CLOSE;
            else begin
               add_char(q.data_byte);
               mode = PARSE_OPEN;
            end
         end
         PARSE_CLOSE: begin
            if (q.data_byte == CHAR_GT) begin
               r = count_tag();
               return 1;
            end
            add_char(q.data_byte);
         end
         default: begin
            if (q.data_byte == CHAR_GT || q.data_byte == CHAR_SPACE) begin
               r = count_tag();
               return 1;
            end
            add_char(q.data_byte);
         end
      endcase
      return 0;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (pending.size() == 0) begin
            $error("report with none expected: %h", rsp_data);
            errors++;
         end else begin
            e = pending.pop_front();
            if (rsp_data.kind != e.kind)
               $error("kind: expected %0d, got %0d", e.kind, rsp_data.kind);
            if (rsp_data.entry_slot != e.entry_slot)
               $error("entry_slot: expected %0d, got %0d", e.entry_slot, rsp_data.entry_slot);
            if (rsp_data.occurrences != e.occurrences)
               $error("occurrences: expected %0d, got %0d", e.occurrences,
                      rsp_data.occurrences);
            if (rsp_data.is_new != e.is_new)
               $error("is_new: expected %0d, got %0d", e.is_new, rsp_data.is_new);
            if (rsp_data.dropped_full != e.dropped_full)
               $error("dropped_full: expected %0d, got %0d", e.dropped_full,
                      rsp_data.dropped_full);
            if (rsp_data.name_char != e.name_char)
               $error("name_char: expected %h, got %h", e.name_char, rsp_data.name_char);
            if (rsp_data.name_length != e.name_length)
               $error("name_length: expected %0d, got %0d", e.name_length,
                      rsp_data.name_length);
            if (rsp_data.entries_used != e.entries_used)
               $error("entries_used: expected %0d, got %0d", e.entries_used,
                      rsp_data.entries_used);
            if (rsp_data !== e) errors++;
            if (e.kind == KIND_TAG) reports++;
            else reads++;
         end
      end
      if (cycles > LIMIT) begin
         $display("timeout with %0d reports outstanding", pending.size());
         $display("** markup_tag_counter_unit: FAILED **");
         $finish;
      end
   end

   // Sends one request after a random gap, then queues its expected report.
   // Start stays high between back-to-back requests and drops during gaps.
   task automatic send_request(req_type q, int gap);
      rsp_type r;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (predict_request(q, r)) pending.push_back(r);
      requests++;
   endtask

   task automatic send_byte(logic [7:0] b);
      req_type q;
      q = '0;
      q.command = CMD_STREAM;
      q.data_byte = b;
      q.slot = 4'($urandom);
      q.char_pos = 5'($urandom);
      send_request(q, $urandom_range(0, 10));
   endtask

   task automatic send_read(logic [3:0] s, logic [4:0] p);
      req_type q;
      q = '0;
      q.command = CMD_READ;
      q.slot = s;
      q.char_pos = p;
      q.data_byte = 8'($urandom);
      send_request(q, $urandom_range(0, 10));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Directed rows: command, byte, slot, position; check marks rows whose
   // report is typed in here as well as predicted.
   typedef struct {
      logic       cmd;
      logic [7:0] b;
      logic [3:0] s;
      logic [4:0] p;
      bit         check;
      rsp_type    want;
   } row_type;

   row_type rows [$];

   task automatic add_row(logic c, logic [7:0] b, logic [3:0] s, logic [4:0] p,
                          bit chk, rsp_type w);
      row_type t;
      t.cmd = c; t.b = b; t.s = s; t.p = p; t.check = chk; t.want = w;
      rows.push_back(t);
   endtask

   task automatic random_tag(int pool);
      int len;
      int closing;
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 3);
      closing = $urandom_range(0, 1);
      send_byte(CHAR_LT);
      if (closing) send_byte(CHAR_SLASH);
      for (int i = 0; i < len; i++) begin
         if (pool) send_byte(8'(8'h61 + $urandom_range(0, 2)));
         else begin
            logic [7:0] b;
            b = 8'($urandom);
            if (i > 0 && (b == CHAR_GT || b == CHAR_SPACE)) b = 8'h80 | b;
            send_byte(b);
         end
      end
      send_byte((!closing && $urandom_range(0, 1)) ? CHAR_SPACE : CHAR_GT);
   endtask

   initial begin
      rsp_type w;
      rsp_type r;
      for (int i = 0; i < ENTRIES; i++) begin
         tag_lens[i] = 0;
         tag_counts[i] = 0;
      end
      mode = PARSE_IDLE;
      cur_len = 0;
      tag_used = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      w = '0; w.kind = KIND_READ; w.entry_slot = 4'd15;
      add_row(CMD_READ, 8'h00, 4'd15, 5'd31, 1, w);
      w = '0;
      add_row(CMD_STREAM, CHAR_LT, 4'd0, 5'd0, 0, w);
      add_row(CMD_STREAM, CHAR_SLASH, 4'd0, 5'd0, 0, w);
      w.kind = KIND_TAG; w.occurrences = 1; w.is_new = 1; w.entries_used = 5'd1;
      add_row(CMD_STREAM, CHAR_GT, 4'd0, 5'd0, 1, w);
      w = '0;
      add_row(CMD_STREAM, CHAR_LT, 4'd0, 5'd0, 0, w);
      add_row(CMD_STREAM, 8'hFF, 4'd0, 5'd0, 0, w);
      add_row(CMD_READ, 8'h00, 4'd0, 5'd0, 0, w);
      add_row(CMD_STREAM, 8'h00, 4'd0, 5'd0, 0, w);
      add_row(CMD_STREAM, CHAR_SPACE, 4'd0, 5'd0, 0, w);
      add_row(CMD_STREAM, CHAR_LT, 4'd0, 5'd0, 0, w);
      add_row(CMD_STREAM, CHAR_GT, 4'd0, 5'd0, 0, w);
      add_row(CMD_STREAM, CHAR_GT, 4'd0, 5'd0, 0, w);
      add_row(CMD_STREAM, CHAR_LT, 4'd0, 5'd0, 0, w);
      add_row(CMD_STREAM, CHAR_LT, 4'd0, 5'd0, 0, w);
      add_row(CMD_STREAM, CHAR_SPACE, 4'd0, 5'd0, 0, w);
      add_row(CMD_READ, 8'h00, 4'd1, 5'd0, 0, w);
      add_row(CMD_READ, 8'h00, 4'd1, 5'd1, 0, w);
      add_row(CMD_READ, 8'h00, 4'd2, 5'd0, 0, w);
      add_row(CMD_READ, 8'h00, 4'd3, 5'd18, 0, w);
      // The model walks every row so that typed-in reports see the right state.
      foreach (rows[i]) begin
         req_type q;
         bit      has;
         q.command = rows[i].cmd; q.data_byte = rows[i].b;
         q.slot = rows[i].s; q.char_pos = rows[i].p;
         r = '0;
         has = predict_request(q, r);
         if (rows[i].check && (!has || r != rows[i].want)) begin
            $error("directed row %0d: table %h, model %h", i, rows[i].want, r);
            errors++;
         end
      end
      // Restart the model from the reset state before the rows are sent.
      tag_used = 0; cur_len = 0; mode = PARSE_IDLE;
      foreach (rows[i]) begin
         req_type q;
         q.command = rows[i].cmd; q.data_byte = rows[i].b;
         q.slot = rows[i].s; q.char_pos = rows[i].p;
         send_request(q, $urandom_range(0, 10));
      end
      // A long name that is truncated, then repeated to match its kept bytes.
      for (int k = 0; k < 2; k++) begin
         send_byte(CHAR_LT);
         for (int i = 0; i < 22 + k; i++) send_byte(8'(8'h41 + i));
         send_byte(CHAR_GT);
      end
      send_read(4'd4, 5'd18);
      send_read(4'd4, 5'd19);
      drain();

      // Random content, mostly well-formed tags over a small alphabet.
      while (requests < 1250) begin
         int pick;
         pick = $urandom_range(0, 9);
         if (pick < 6) random_tag(pick < 4);
         else if (pick < 8) send_read(4'($urandom), 5'($urandom_range(0, 31)));
         else send_byte(8'($urandom));
         if (requests > 600 && requests < 620) drain();
      end
      // Fill the table so names get dropped.
      for (int n = 0; n < ENTRIES + 3; n++) begin
         send_byte(CHAR_LT);
         send_byte(8'(8'hC0 + n));
         send_byte(8'(8'hD0 + n));
         send_byte(CHAR_GT);
      end
      for (int s = 0; s < ENTRIES; s++) send_read(4'(s), 5'($urandom_range(0, 31)));
      drain();

      $display("%0d requests: %0d tag reports, %0d read replies, %0d table entries used",
               requests, reports, reads, tag_used);
      if (errors == 0) $display("** markup_tag_counter_unit: PASSED **");
      else $display("** markup_tag_counter_unit: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/mtc_pkg.sv
src/mtc_ctrl.sv
src/mtc_datapath.sv
src/markup_tag_counter_unit.sv
tb/markup_tag_counter_unit_test.sv
